// File: design/kpd_pkg.sv
// Shared types and constants for the keypad debounce and release detector.
// No dependencies; every design file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package kpd_pkg;

  localparam int KEY_COUNT = 16;
  localparam int KEY_IDX_W = 4;
  localparam int CHAR_W    = 7;

  typedef logic [KEY_COUNT-1:0] key_vec_t;
  typedef logic [KEY_IDX_W-1:0] key_idx_t;
  typedef logic [CHAR_W-1:0]    key_char_t;

  typedef struct packed {
    logic      valid;
    key_idx_t  key_index;
    key_char_t key_char;
  } release_t;

  function automatic key_char_t key_legend(input key_idx_t idx);
    key_char_t c;
    unique case (idx)
      4'd0:    c = 7'h31;  // '1'
      4'd1:    c = 7'h32;  // '2'
      4'd2:    c = 7'h33;  // '3'
      4'd3:    c = 7'h41;  // 'A'
      4'd4:    c = 7'h34;  // '4'
      4'd5:    c = 7'h35;  // '5'
      4'd6:    c = 7'h36;  // '6'
      4'd7:    c = 7'h42;  // 'B'
      4'd8:    c = 7'h37;  // '7'
      4'd9:    c = 7'h38;  // '8'
      4'd10:   c = 7'h39;  // '9'
      4'd11:   c = 7'h43;  // 'C'
      4'd12:   c = 7'h2a;  // '*'
      4'd13:   c = 7'h30;  // '0'
      4'd14:   c = 7'h23;  // '#'
      4'd15:   c = 7'h44;  // 'D'
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/kpd_input_stage.sv
// Input register for one scan tick of sampled key levels.
// Depends on kpd_pkg for the key vector type.
`timescale 1ns / 1ps
`default_nettype none

module kpd_input_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire kpd_pkg::key_vec_t in_key_levels,
  output logic                   in_stall,
  input  wire logic              adv,
  output logic                   tick_valid,
  output kpd_pkg::key_vec_t      tick_levels
);

  logic              valid_r, valid_nxt;
  kpd_pkg::key_vec_t levels_r;
  logic              take;

  assign in_stall = valid_r && !adv;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      levels_r <= in_key_levels;
    end
  end

  assign tick_valid  = valid_r;
  assign tick_levels = levels_r;

endmodule

`default_nettype wire

// File: design/kpd_scan_core.sv
// Per-key level histories, held flags and the lowest-index release pick.
// Depends on kpd_pkg for types and the keypad legend.
`timescale 1ns / 1ps
`default_nettype none

module kpd_scan_core #(
  parameter int HISTORY_BITS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire kpd_pkg::key_vec_t tick_levels,
  output kpd_pkg::release_t      rel
);

  typedef logic [HISTORY_BITS-1:0] hist_t;

  hist_t             hist_r   [kpd_pkg::KEY_COUNT];
  hist_t             hist_nxt [kpd_pkg::KEY_COUNT];
  kpd_pkg::key_vec_t held_r, held_nxt;
  kpd_pkg::key_vec_t all_ones, all_zero, rel_cand;
  logic              seen;
  kpd_pkg::key_idx_t pick;

  always_comb begin
    for (int k = 0; k < kpd_pkg::KEY_COUNT; k++) begin
      hist_nxt[k] = {hist_r[k][HISTORY_BITS-2:0], tick_levels[k]};
      all_ones[k] = &hist_nxt[k];
      all_zero[k] = ~|hist_nxt[k];
      rel_cand[k] = all_zero[k] && held_r[k];
    end
  end

  // Check keys in index order; stop after the first release.
  always_comb begin
    seen     = 1'b0;
    pick     = '0;
    held_nxt = held_r;
    for (int k = 0; k < kpd_pkg::KEY_COUNT; k++) begin
      if (!seen) begin
        if (all_ones[k]) begin
          held_nxt[k] = 1'b1;
        end else if (all_zero[k]) begin
          held_nxt[k] = 1'b0;
        end
        if (rel_cand[k]) begin
          pick = kpd_pkg::key_idx_t'(k);
        end
      end
      seen = seen | rel_cand[k];
    end
  end

  assign rel.valid     = seen;
  assign rel.key_index = pick;
  assign rel.key_char  = kpd_pkg::key_legend(pick);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      for (int k = 0; k < kpd_pkg::KEY_COUNT; k++) begin
        hist_r[k] <= '0;
      end
    end else if (adv) begin
      held_r <= held_nxt;
      for (int k = 0; k < kpd_pkg::KEY_COUNT; k++) begin
        hist_r[k] <= hist_nxt[k];
      end
    end
  end

endmodule

`default_nettype wire

// File: design/kpd_output_stage.sv
// Result register holding one released key until the receiver takes it.
// Depends on kpd_pkg for the release struct.
`timescale 1ns / 1ps
`default_nettype none

module kpd_output_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              adv,
  input  wire kpd_pkg::release_t rel,
  output logic                   slot_ready,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output kpd_pkg::key_idx_t      out_key_index,
  output kpd_pkg::key_char_t     out_key_char
);

  logic               valid_r, valid_nxt;
  kpd_pkg::key_idx_t  index_r;
  kpd_pkg::key_char_t char_r;

  assign slot_ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (adv) begin
      valid_nxt = rel.valid;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && rel.valid) begin
      index_r <= rel.key_index;
      char_r  <= rel.key_char;
    end
  end

  assign out_valid     = valid_r;
  assign out_key_index = index_r;
  assign out_key_char  = char_r;

endmodule

`default_nettype wire

// File: design/keypad_debounce_release_detect_top.sv
// Keypad debounce and release detector, top level.
// Depends on kpd_pkg, kpd_input_stage, kpd_scan_core and kpd_output_stage.
//
// Input channel (in_valid / in_stall / in_key_levels): one transfer is one scan
// tick of sixteen sampled key levels, bit k = row*4 + column, 1 = pressed.
// Every key shifts its level into a HISTORY_BITS-wide history; a full history
// of ones marks the key held, and a history of zeros on a held key releases it.
// Result channel (out_valid / out_stall / out_key_index / out_key_char): one
// transfer per reported release, lowest index first, at most one per tick.
// Ticks that release nothing produce no transfer.
// Path: a tick goes through the input register, then the result register;
// out_valid rises once the result register has taken the tick's release.
// Throughput: one tick per cycle while out_stall holds no pending result, set
// by the combinational history update and priority pick between the registers.
// While out_stall holds a pending result, one further tick can wait in the
// input register; in_stall rises only when that register is also full.
// Reset (rst_n low, synchronous) clears all histories, all held flags and both
// valid registers.
`timescale 1ns / 1ps
`default_nettype none

module keypad_debounce_release_detect_top #(
  parameter int HISTORY_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire kpd_pkg::key_vec_t  in_key_levels,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output kpd_pkg::key_idx_t       out_key_index,
  output kpd_pkg::key_char_t      out_key_char
);

  logic              tick_valid;
  kpd_pkg::key_vec_t tick_levels;
  logic              slot_ready;
  logic              adv;
  kpd_pkg::release_t rel;

  assign adv = tick_valid && slot_ready;

  kpd_input_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_key_levels(in_key_levels),
    .in_stall     (in_stall),
    .adv          (adv),
    .tick_valid   (tick_valid),
    .tick_levels  (tick_levels)
  );

  kpd_scan_core #(
    .HISTORY_BITS(HISTORY_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .tick_levels(tick_levels),
    .rel        (rel)
  );

  kpd_output_stage u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .rel          (rel),
    .slot_ready   (slot_ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_key_index(out_key_index),
    .out_key_char (out_key_char)
  );

  a_rel_lands: assert property (@(posedge clk) disable iff (!rst_n)
    adv && rel.valid |=> out_valid)
    else $error("release not registered at output");

  a_char_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_key_char == kpd_pkg::key_legend(out_key_index))
    else $error("key_char does not match key_index");

  a_stall_keeps_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> tick_valid && !slot_ready)
    else $error("input stalled without a blocked tick");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !tick_valid)
    else $error("reset did not clear valid registers");

endmodule

`default_nettype wire
